FILE: src/css2d_pkg.sv
// shared constants, types and register codes of the cross stencil block
package css2d_pkg;

    localparam int RADIUS_DEF     = 3;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 1;
    localparam int ROW_BITS       = 11;
    localparam int HEIGHT_LIMIT   = 1024;
    localparam int POS_BITS       = 10;
    localparam int SUM_OUT_BITS   = 20;
    localparam int WIDTH_RESET    = 518;
    localparam int HEIGHT_RESET   = 518;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                emit;
        logic                border;
        logic                last;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } meta_t;

endpackage

FILE: src/css2d_queue.sv
// small fifo between the front and back parts of the stencil block
module css2d_queue #(
    parameter int DATA_BITS = $bits(css2d_pkg::meta_t) + 2 * css2d_pkg::PIXEL_BITS_DEF
                              + $clog2(2 * css2d_pkg::RADIUS_DEF)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [DATA_BITS-1:0]            data_in,
    input  logic                            pop,
    output logic [DATA_BITS-1:0]            data_out,
    output logic                            empty,
    output logic [css2d_pkg::QCNT_BITS-1:0] count
);

    logic [DATA_BITS-1:0]            mem_reg [css2d_pkg::QUEUE_DEPTH];
    logic [css2d_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [css2d_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [css2d_pkg::QCNT_BITS-1:0] count_reg;
    logic [css2d_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [css2d_pkg::QPTR_BITS-1:0] rd_ptr_next;

    always_comb
    begin
        if (wr_ptr_reg == css2d_pkg::QPTR_BITS'(css2d_pkg::QUEUE_DEPTH - 1))
        begin
            wr_ptr_next = '0;
        end
        else
        begin
            wr_ptr_next = wr_ptr_reg + css2d_pkg::QPTR_BITS'(1);
        end
        if (rd_ptr_reg == css2d_pkg::QPTR_BITS'(css2d_pkg::QUEUE_DEPTH - 1))
        begin
            rd_ptr_next = '0;
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg + css2d_pkg::QPTR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + css2d_pkg::QCNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - css2d_pkg::QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

    assign data_out = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

FILE: src/css2d_front.sv
// front part: frame counters, line buffers and column gather
module css2d_front #(
    parameter int RADIUS_TAPS = css2d_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH   = css2d_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS  = css2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [css2d_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [css2d_pkg::CFG_BITS-1:0]       wr_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 action,
    input  logic signed [PIXEL_BITS-1:0]         pixel_value,
    input  logic [css2d_pkg::QCNT_BITS-1:0]      q_count,
    output logic                                 q_push,
    output logic [$bits(css2d_pkg::meta_t) + 2 * PIXEL_BITS
                  + $clog2(2 * RADIUS_TAPS) - 1:0] q_data
);

    localparam int WIN_ROWS  = 2 * RADIUS_TAPS + 1;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int WSUM_BITS = WID_BITS + 1;
    localparam int WCMP_BITS = (WID_BITS > css2d_pkg::CFG_BITS) ? WID_BITS
                                                                : css2d_pkg::CFG_BITS;
    localparam int BANK_BITS = $clog2(WIN_ROWS);
    localparam int VSUM_BITS = PIXEL_BITS + $clog2(2 * RADIUS_TAPS);
    localparam int OCC_BITS  = css2d_pkg::QCNT_BITS + 1;
    localparam int ROW_BITS  = css2d_pkg::ROW_BITS;

    logic [css2d_pkg::CFG_BITS-1:0] frame_width_reg;
    logic [css2d_pkg::CFG_BITS-1:0] frame_height_reg;

    logic [ROW_BITS-1:0]  in_row_reg;
    logic [COL_BITS-1:0]  in_col_reg;
    logic [ROW_BITS-1:0]  out_row_reg;
    logic [COL_BITS-1:0]  out_col_reg;
    logic [WID_BITS-1:0]  cur_w_reg;
    logic [ROW_BITS-1:0]  cur_h_reg;
    logic [BANK_BITS-1:0] bank_reg;

    logic                         f1_valid_reg;
    css2d_pkg::meta_t             f1_meta_reg;
    logic signed [PIXEL_BITS-1:0] f1_pixel_reg;
    logic [BANK_BITS-1:0]         f1_bank_reg;
    logic signed [PIXEL_BITS-1:0] rd_data_reg [WIN_ROWS];

    logic                         f2_valid_reg;
    css2d_pkg::meta_t             f2_meta_reg;
    logic signed [PIXEL_BITS-1:0] f2_col_reg [WIN_ROWS];

    logic [WCMP_BITS-1:0]         cfg_w;
    logic [WID_BITS-1:0]          clamp_w;
    logic [ROW_BITS-1:0]          clamp_h;
    logic [WID_BITS-1:0]          w;
    logic [ROW_BITS-1:0]          h;
    logic                         frame_start;
    logic                         in_frame;
    logic                         accept;
    logic                         step;
    logic                         wr_pix;
    logic                         col_wrap;
    logic                         out_col_wrap;
    logic                         emit;
    logic                         last;
    logic                         border;
    css2d_pkg::meta_t             cur_meta;
    logic [BANK_BITS-1:0]         bank_idx [WIN_ROWS];
    logic signed [PIXEL_BITS-1:0] col_sel [WIN_ROWS];
    logic signed [VSUM_BITS-1:0]  vsum;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= css2d_pkg::CFG_BITS'(css2d_pkg::WIDTH_RESET);
            frame_height_reg <= css2d_pkg::CFG_BITS'(css2d_pkg::HEIGHT_RESET);
        end
        else if (wr_en)
        begin
            case (css2d_pkg::cfg_reg_t'(wr_index))
                css2d_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= wr_data;
                css2d_pkg::REG_FRAME_HEIGHT: frame_height_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // frame size, clamped and latched at the first transaction of a frame
    always_comb
    begin
        cfg_w = WCMP_BITS'(frame_width_reg);
        if (cfg_w < WCMP_BITS'(WIN_ROWS))
        begin
            clamp_w = WID_BITS'(WIN_ROWS);
        end
        else if (cfg_w > WCMP_BITS'(MAX_WIDTH))
        begin
            clamp_w = WID_BITS'(MAX_WIDTH);
        end
        else
        begin
            clamp_w = WID_BITS'(cfg_w);
        end
        if (ROW_BITS'(frame_height_reg) < ROW_BITS'(WIN_ROWS))
        begin
            clamp_h = ROW_BITS'(WIN_ROWS);
        end
        else if (ROW_BITS'(frame_height_reg) > ROW_BITS'(css2d_pkg::HEIGHT_LIMIT))
        begin
            clamp_h = ROW_BITS'(css2d_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            clamp_h = ROW_BITS'(frame_height_reg);
        end
    end

    assign frame_start  = (in_row_reg == '0) && (in_col_reg == '0);
    assign w            = frame_start ? clamp_w : cur_w_reg;
    assign h            = frame_start ? clamp_h : cur_h_reg;
    assign in_frame     = (in_row_reg < h);
    assign full         = (OCC_BITS'(q_count) + OCC_BITS'(f1_valid_reg)
                           + OCC_BITS'(f2_valid_reg)) >= OCC_BITS'(css2d_pkg::QUEUE_DEPTH);
    assign accept       = push && !full;
    // flush before the last pixel is dropped without effect
    assign step         = accept && !(in_frame && action);
    assign wr_pix       = step && in_frame;
    assign col_wrap     = (WID_BITS'(in_col_reg) + WID_BITS'(1)) == w;
    assign out_col_wrap = (WID_BITS'(out_col_reg) + WID_BITS'(1)) == w;
    assign emit         = (in_row_reg > ROW_BITS'(RADIUS_TAPS))
                          || ((in_row_reg == ROW_BITS'(RADIUS_TAPS))
                              && (in_col_reg >= COL_BITS'(RADIUS_TAPS)));
    assign last         = emit && (out_row_reg == (h - ROW_BITS'(1))) && out_col_wrap;
    assign border       = (out_row_reg < ROW_BITS'(RADIUS_TAPS))
                          || ((out_row_reg + ROW_BITS'(RADIUS_TAPS)) >= h)
                          || (out_col_reg < COL_BITS'(RADIUS_TAPS))
                          || ((WSUM_BITS'(out_col_reg) + WSUM_BITS'(RADIUS_TAPS))
                              >= WSUM_BITS'(w));

    always_comb
    begin
        cur_meta.emit   = emit;
        cur_meta.border = border;
        cur_meta.last   = last;
        cur_meta.row    = css2d_pkg::POS_BITS'(out_row_reg);
        cur_meta.col    = css2d_pkg::POS_BITS'(out_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            cur_w_reg    <= '0;
            cur_h_reg    <= '0;
            bank_reg     <= '0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= step;
            f2_valid_reg <= f1_valid_reg;
            if (step)
            begin
                cur_w_reg <= w;
                cur_h_reg <= h;
                if (last)
                begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
                else
                begin
                    if (col_wrap)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + ROW_BITS'(1);
                        if (bank_reg == BANK_BITS'(WIN_ROWS - 1))
                        begin
                            bank_reg <= '0;
                        end
                        else
                        begin
                            bank_reg <= bank_reg + BANK_BITS'(1);
                        end
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + COL_BITS'(1);
                    end
                    if (emit)
                    begin
                        if (out_col_wrap)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + ROW_BITS'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + COL_BITS'(1);
                        end
                    end
                end
            end
        end
    end

    // one line buffer per row of the window
    for (genvar b = 0; b < WIN_ROWS; b++)
    begin : g_bank
        logic signed [PIXEL_BITS-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (wr_pix && (bank_reg == BANK_BITS'(b)))
            begin
                mem[in_col_reg] <= pixel_value;
            end
            if (step)
            begin
                rd_data_reg[b] <= mem[in_col_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            f1_meta_reg  <= cur_meta;
            f1_pixel_reg <= pixel_value;
            f1_bank_reg  <= bank_reg;
        end
        if (f1_valid_reg)
        begin
            f2_meta_reg <= f1_meta_reg;
            for (int k = 0; k < WIN_ROWS; k++)
            begin
                f2_col_reg[k] <= col_sel[k];
            end
        end
    end

    // column gather: entry k is the row k rows above the newest one
    always_comb
    begin
        bank_idx[0] = f1_bank_reg;
        col_sel[0]  = f1_pixel_reg;
        for (int k = 1; k < WIN_ROWS; k++)
        begin
            if (f1_bank_reg >= BANK_BITS'(k))
            begin
                bank_idx[k] = f1_bank_reg - BANK_BITS'(k);
            end
            else
            begin
                bank_idx[k] = f1_bank_reg + BANK_BITS'(WIN_ROWS - k);
            end
            col_sel[k] = rd_data_reg[bank_idx[k]];
        end
    end

    // vertical arm sum without the centre row
    always_comb
    begin
        vsum = '0;
        for (int k = 0; k < WIN_ROWS; k++)
        begin
            if (k != RADIUS_TAPS)
            begin
                vsum = vsum + VSUM_BITS'(f2_col_reg[k]);
            end
        end
    end

    assign q_push = f2_valid_reg;
    assign q_data = {f2_meta_reg, f2_col_reg[RADIUS_TAPS], vsum};

endmodule

FILE: src/css2d_back.sv
// back part: horizontal window, final sum and result register
module css2d_back #(
    parameter int RADIUS_TAPS = css2d_pkg::RADIUS_DEF,
    parameter int PIXEL_BITS  = css2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  logic [$bits(css2d_pkg::meta_t) + 2 * PIXEL_BITS
                  + $clog2(2 * RADIUS_TAPS) - 1:0] q_data,
    output logic                                   q_pop,
    input  logic                                   pop,
    output logic                                   empty,
    output logic signed [css2d_pkg::SUM_OUT_BITS-1:0] stencil_sum,
    output logic [css2d_pkg::POS_BITS-1:0]         out_row,
    output logic [css2d_pkg::POS_BITS-1:0]         out_col,
    output logic                                   is_border,
    output logic                                   frame_last
);

    localparam int WIN_ROWS     = 2 * RADIUS_TAPS + 1;
    localparam int VSUM_BITS    = PIXEL_BITS + $clog2(2 * RADIUS_TAPS);
    localparam int SUM_RAW_BITS = PIXEL_BITS + $clog2(4 * RADIUS_TAPS + 1);
    localparam int ACC_BITS     = (SUM_RAW_BITS > css2d_pkg::SUM_OUT_BITS)
                                  ? SUM_RAW_BITS : css2d_pkg::SUM_OUT_BITS;

    css2d_pkg::meta_t             rec_meta;
    logic signed [PIXEL_BITS-1:0] rec_centre;
    logic signed [VSUM_BITS-1:0]  rec_vsum;

    logic signed [PIXEL_BITS-1:0] cwin_reg [WIN_ROWS];
    logic signed [VSUM_BITS-1:0]  vdly_reg [RADIUS_TAPS + 1];
    logic                         b1_valid_reg;
    css2d_pkg::meta_t             b1_meta_reg;
    logic                         out_valid_reg;
    logic signed [css2d_pkg::SUM_OUT_BITS-1:0] out_sum_reg;
    css2d_pkg::meta_t             out_meta_reg;

    logic                         out_ready;
    logic                         b1_adv;
    logic                         load_out;
    logic signed [ACC_BITS-1:0]   acc;
    logic signed [ACC_BITS-1:0]   result;

    assign {rec_meta, rec_centre, rec_vsum} = q_data;

    assign out_ready = !out_valid_reg || pop;
    assign b1_adv    = !b1_valid_reg || !b1_meta_reg.emit || out_ready;
    assign q_pop     = !q_empty && b1_adv;
    assign load_out  = b1_valid_reg && b1_meta_reg.emit && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_adv)
            begin
                b1_valid_reg <= q_pop;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // windows move one place per transaction taken from the queue
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_meta_reg <= rec_meta;
            cwin_reg[0] <= rec_centre;
            vdly_reg[0] <= rec_vsum;
            for (int k = 1; k < WIN_ROWS; k++)
            begin
                cwin_reg[k] <= cwin_reg[k-1];
            end
            for (int k = 1; k <= RADIUS_TAPS; k++)
            begin
                vdly_reg[k] <= vdly_reg[k-1];
            end
        end
        if (load_out)
        begin
            out_sum_reg  <= css2d_pkg::SUM_OUT_BITS'(result);
            out_meta_reg <= b1_meta_reg;
        end
    end

    always_comb
    begin
        acc = ACC_BITS'(vdly_reg[RADIUS_TAPS]);
        for (int k = 0; k < WIN_ROWS; k++)
        begin
            acc = acc + ACC_BITS'(cwin_reg[k]);
        end
        if (b1_meta_reg.border)
        begin
            result = ACC_BITS'(cwin_reg[RADIUS_TAPS]);
        end
        else
        begin
            result = acc;
        end
    end

    assign empty       = !out_valid_reg;
    assign stencil_sum = out_sum_reg;
    assign out_row     = out_meta_reg.row;
    assign out_col     = out_meta_reg.col;
    assign is_border   = out_meta_reg.border;
    assign frame_last  = out_meta_reg.last;

endmodule

FILE: src/cross_stencil_sum_2d.sv
// top level of the streaming 2-d cross stencil sum
//
// input queue: drive action and pixel_value with push; a transaction is taken
// at a clock edge with push high and full low. pixels come in row-major order;
// after the last pixel of a frame, flush transactions (action high) drain the
// final results. a flush before the last pixel is taken and dropped.
// result queue: while empty is low the oldest result sits on stencil_sum,
// out_row, out_col, is_border and frame_last; pop high takes it.
// configuration: wr_en with wr_index and wr_data writes frame_width or
// frame_height; the size is latched at the first transaction of a frame.
// throughput: one transaction per cycle while full is low, set by the
// single-port line buffers read once per pixel. the result for a position is
// registered after the transaction RADIUS_TAPS rows and RADIUS_TAPS pixels later.
// when the result side stalls, a 4-entry queue and the result register fill
// and full rises; nothing is lost. reset clears all counters and queues, and
// the block accepts transactions from the first cycle after reset.
module cross_stencil_sum_2d #(
    parameter int RADIUS_TAPS = css2d_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH   = css2d_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS  = css2d_pkg::PIXEL_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      wr_en,
    input  logic [css2d_pkg::CFG_INDEX_BITS-1:0]      wr_index,
    input  logic [css2d_pkg::CFG_BITS-1:0]            wr_data,
    input  logic                                      push,
    output logic                                      full,
    input  logic                                      action,
    input  logic signed [PIXEL_BITS-1:0]              pixel_value,
    output logic                                      empty,
    input  logic                                      pop,
    output logic signed [css2d_pkg::SUM_OUT_BITS-1:0] stencil_sum,
    output logic [css2d_pkg::POS_BITS-1:0]            out_row,
    output logic [css2d_pkg::POS_BITS-1:0]            out_col,
    output logic                                      is_border,
    output logic                                      frame_last
);

    localparam int QDATA_BITS = $bits(css2d_pkg::meta_t) + 2 * PIXEL_BITS
                                + $clog2(2 * RADIUS_TAPS);

    logic                            q_push;
    logic [QDATA_BITS-1:0]           q_wdata;
    logic                            q_pop;
    logic [QDATA_BITS-1:0]           q_rdata;
    logic                            q_empty;
    logic [css2d_pkg::QCNT_BITS-1:0] q_count;

    css2d_front #(
        .RADIUS_TAPS (RADIUS_TAPS),
        .MAX_WIDTH   (MAX_WIDTH),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .push        (push),
        .full        (full),
        .action      (action),
        .pixel_value (pixel_value),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    css2d_queue #(
        .DATA_BITS (QDATA_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_wdata),
        .pop      (q_pop),
        .data_out (q_rdata),
        .empty    (q_empty),
        .count    (q_count)
    );

    css2d_back #(
        .RADIUS_TAPS (RADIUS_TAPS),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .stencil_sum (stencil_sum),
        .out_row     (out_row),
        .out_col     (out_col),
        .is_border   (is_border),
        .frame_last  (frame_last)
    );

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the streaming 2-d cross stencil sum block
module testbench;
    import css2d_pkg::*;

    localparam int RAD         = RADIUS_DEF;
    localparam int WIN         = 2 * RAD + 1;
    localparam int MAXW        = MAX_WIDTH_DEF;
    localparam int PIX         = PIXEL_BITS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_ITEMS  = 250;

    typedef enum bit {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic signed [SUM_OUT_BITS-1:0] sum;
        logic [POS_BITS-1:0]            row;
        logic [POS_BITS-1:0]            col;
        logic                           border;
        logic                           last;
    } stencil_res_t;

    class stencil_tracker;
        logic signed [PIX-1:0] lines [WIN][MAXW];
        int unsigned           width_reg;
        int unsigned           height_reg;
        int unsigned           cur_w;
        int unsigned           cur_h;
        int unsigned           row_cnt;
        int unsigned           col_cnt;
        int unsigned           emitted;
        stencil_res_t          due_sums [$];
        int unsigned           mismatches;

        function new();
            foreach (lines[r, c])
                lines[r][c] = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            cur_w      = clamp_dim(width_reg, MAXW);
            cur_h      = clamp_dim(height_reg, HEIGHT_LIMIT);
            row_cnt    = 0;
            col_cnt    = 0;
            emitted    = 0;
            mismatches = 0;
        endfunction

        static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < WIN)
                v = WIN;
            if (v > hi)
                v = hi;
            return v;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] v);
            if (idx == REG_FRAME_WIDTH)
                width_reg = v;
            else
                height_reg = v;
        endfunction

        function int at(int unsigned r, int unsigned c);
            return lines[r % WIN][c % MAXW];
        endfunction

        function void note_transaction(item_kind_t kind, logic signed [PIX-1:0] pix);
            int unsigned  n;
            int unsigned  lag;
            int unsigned  total;
            int unsigned  p;
            int unsigned  pr;
            int unsigned  pc;
            int           sum;
            bit           border;
            stencil_res_t r;

            if (row_cnt == 0 && col_cnt == 0 && emitted == 0)
            begin
                cur_w = clamp_dim(width_reg, MAXW);
                cur_h = clamp_dim(height_reg, HEIGHT_LIMIT);
            end
            if (row_cnt < cur_h)
            begin
                if (kind == ACT_FLUSH)
                    return;
                lines[row_cnt % WIN][col_cnt] = pix;
            end
            n     = row_cnt * cur_w + col_cnt;
            lag   = RAD * cur_w + RAD;
            total = cur_w * cur_h;
            col_cnt++;
            if (col_cnt >= cur_w)
            begin
                col_cnt = 0;
                row_cnt++;
            end
            if (n < lag)
                return;
            p = n - lag;
            if (p >= total || emitted >= total)
                return;
            pr     = p / cur_w;
            pc     = p % cur_w;
            border = pr < RAD || pr + RAD >= cur_h || pc < RAD || pc + RAD >= cur_w;
            sum    = at(pr, pc);
            if (!border)
            begin
                for (int k = 1; k <= RAD; k++)
                begin
                    sum += at(pr - k, pc);
                    sum += at(pr + k, pc);
                    sum += at(pr, pc - k);
                    sum += at(pr, pc + k);
                end
            end
            emitted++;
            r.sum    = sum[SUM_OUT_BITS-1:0];
            r.row    = pr[POS_BITS-1:0];
            r.col    = pc[POS_BITS-1:0];
            r.border = border;
            r.last   = (emitted == total);
            due_sums.push_back(r);
            if (emitted == total)
            begin
                row_cnt = 0;
                col_cnt = 0;
                emitted = 0;
            end
        endfunction

        function void check_result(stencil_res_t got);
            stencil_res_t want;

            if (due_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: sum %0d row %0d col %0d", $time,
                             got.sum, got.row, got.col);
                return;
            end
            want = due_sums.pop_front();
            if (got.sum !== want.sum || got.row !== want.row || got.col !== want.col ||
                got.border !== want.border || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at %0t (exp/act): sum %0d/%0d row %0d/%0d ",
                              "col %0d/%0d border %0b/%0b last %0b/%0b"}, $time,
                             want.sum, got.sum, want.row, got.row, want.col, got.col,
                             want.border, got.border, want.last, got.last);
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           wr_en;
    cfg_reg_t                       wr_index;
    logic [CFG_BITS-1:0]            wr_data;
    logic                           push;
    logic                           full;
    logic                           action;
    logic signed [PIX-1:0]          pixel_value;
    logic                           empty;
    logic                           pop;
    logic signed [SUM_OUT_BITS-1:0] stencil_sum;
    logic [POS_BITS-1:0]            out_row;
    logic [POS_BITS-1:0]            out_col;
    logic                           is_border;
    logic                           frame_last;

    stencil_tracker tracker;
    int unsigned    items_sent;
    int unsigned    results_seen;
    int unsigned    quiet_cycles;
    bit             send_calm;
    bit             take_calm;

    cross_stencil_sum_2d DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .push        (push),
        .full        (full),
        .action      (action),
        .pixel_value (pixel_value),
        .empty       (empty),
        .pop         (pop),
        .stencil_sum (stencil_sum),
        .out_row     (out_row),
        .out_col     (out_col),
        .is_border   (is_border),
        .frame_last  (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic signed [PIX-1:0] pick_pixel();
        logic signed [PIX-1:0] v;

        v = PIX'($urandom);
        case ($urandom_range(0, 7))
            0: v = {1'b0, {(PIX-1){1'b1}}};
            1: v = {1'b1, {(PIX-1){1'b0}}};
            2: v = '0;
            3: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(item_kind_t kind, logic signed [PIX-1:0] pix);
        int unsigned gap;

        gap = send_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        action      <= kind;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (full);
        tracker.note_transaction(kind, pix);
        if ($urandom_range(0, 31) == 0)
            send_calm = ($urandom_range(0, 1) == 1);
    endtask

    task automatic go_idle();
        push <= 1'b0;
        while (tracker.due_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_frame(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        wr_en    <= 1'b1;
        wr_index <= REG_FRAME_WIDTH;
        wr_data  <= w;
        @(posedge clk);
        tracker.write_reg(REG_FRAME_WIDTH, w);
        wr_index <= REG_FRAME_HEIGHT;
        wr_data  <= h;
        @(posedge clk);
        tracker.write_reg(REG_FRAME_HEIGHT, h);
        wr_en <= 1'b0;
    endtask

    task automatic feed_pixels(int unsigned count, bit fixed, logic signed [PIX-1:0] val);
        for (int unsigned i = 0; i < count; i++)
        begin
            // early flush, dropped by the block
            if ($urandom_range(0, 19) == 0)
                send_item(ACT_FLUSH, pick_pixel());
            send_item(ACT_PIXEL, fixed ? val : pick_pixel());
            items_sent++;
        end
    endtask

    task automatic drain_frame(int unsigned ew);
        for (int unsigned i = 0; i < RAD * ew + RAD; i++)
        begin
            send_item(item_kind_t'($urandom_range(0, 1)), pick_pixel());
            items_sent++;
        end
    endtask

    task automatic run_frame(int unsigned wraw, int unsigned hraw);
        int unsigned ew;
        int unsigned eh;

        ew = stencil_tracker::clamp_dim(wraw, MAXW);
        eh = stencil_tracker::clamp_dim(hraw, HEIGHT_LIMIT);
        go_idle();
        set_frame(CFG_BITS'(wraw), CFG_BITS'(hraw));
        feed_pixels(ew * eh, 1'b0, '0);
        drain_frame(ew);
    endtask

    task automatic take_results();
        int unsigned gap;

        forever
        begin
            gap = take_calm ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            tracker.check_result('{sum: stencil_sum, row: out_row, col: out_col,
                                   border: is_border, last: frame_last});
            results_seen++;
            // long hold-off so the input side backs up
            if (results_seen == 150 || results_seen == 5000)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if ($urandom_range(0, 31) == 0)
                take_calm = ($urandom_range(0, 1) == 1);
        end
    endtask

    initial
    begin
        int unsigned rand_start;

        tracker      = new();
        items_sent   = 0;
        results_seen = 0;
        quiet_cycles = 0;
        send_calm    = 1'b0;
        take_calm    = 1'b0;
        rst_n       <= 1'b0;
        wr_en       <= 1'b0;
        wr_index    <= REG_FRAME_WIDTH;
        wr_data     <= '0;
        push        <= 1'b0;
        action      <= ACT_PIXEL;
        pixel_value <= '0;
        pop         <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            take_results();
        join_none

        // sizes below the minimum clamp up to 7x7
        set_frame(CFG_BITS'(0), CFG_BITS'(3));
        send_item(ACT_FLUSH, '1);
        feed_pixels(WIN * WIN, 1'b1, {1'b0, {(PIX-1){1'b1}}});
        drain_frame(WIN);
        feed_pixels(WIN * WIN, 1'b1, {1'b1, {(PIX-1){1'b0}}});
        drain_frame(WIN);

        // size written mid-frame only applies to the next frame
        go_idle();
        feed_pixels(5, 1'b0, '0);
        go_idle();
        set_frame(CFG_BITS'(9), CFG_BITS'(WIN));
        feed_pixels(WIN * WIN - 5, 1'b0, '0);
        drain_frame(WIN);
        feed_pixels(9 * WIN, 1'b0, '0);
        drain_frame(9);

        rand_start = items_sent;
        while (items_sent < rand_start + RAND_ITEMS)
            run_frame($urandom_range(0, 16), $urandom_range(0, 10));

        go_idle();
        if (tracker.mismatches == 0 && tracker.due_sums.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
